[rtl/sjp_pkg.sv]
// shared types and constants of the speedup-aware job picker
package sjp_pkg;

  localparam int SPD_W      = 16;
  localparam int ENT_W      = 6;
  localparam int MODE_W     = 3;
  localparam int THR_W      = 3;
  localparam int NUM_W      = 7;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PICK = 1'b1;

  localparam logic [MODE_W-1:0] MODE_CPU      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GPU      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GPU_ONLY = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ADAPTIVE = 3'd3;

  localparam logic [THR_W-1:0] GPU_THREAD = 3'd0;

  localparam logic [SPD_W-1:0] Q_ONE = 16'd256;

  localparam logic [1:0] REG_NUM_ENTRIES   = 2'd0;
  localparam logic [1:0] REG_CPU_RUN_LIMIT = 2'd1;
  localparam logic [1:0] REG_GPU_RUN_FLOOR = 2'd2;

  localparam logic [NUM_W-1:0] RST_NUM_ENTRIES   = 7'd0;
  localparam logic [SPD_W-1:0] RST_CPU_RUN_LIMIT = 16'd768;
  localparam logic [SPD_W-1:0] RST_GPU_RUN_FLOOR = 16'd128;

  typedef struct packed {
    logic [NUM_W-1:0] num_entries;
    logic [SPD_W-1:0] cpu_run_limit;
    logic [SPD_W-1:0] gpu_run_floor;
  } cfg_t;

endpackage

[rtl/sjp_if.sv]
// request and result channel interfaces of the job picker
interface sjp_in_if;
  import sjp_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ENT_W-1:0]  entry_index;
  logic [SPD_W-1:0]  speedup;
  logic              need_coop;
  logic [MODE_W-1:0] run_mode;
  logic [THR_W-1:0]  thread_id;
  logic [MODE_W-1:0] prior_mode;

  modport source (
    output valid, op, entry_index, speedup, need_coop, run_mode, thread_id, prior_mode,
    input  ready
  );
  modport sink (
    input  valid, op, entry_index, speedup, need_coop, run_mode, thread_id, prior_mode,
    output ready
  );
endinterface

interface sjp_out_if;
  import sjp_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [ENT_W-1:0]  job_index;
  logic [MODE_W-1:0] prefer_mode;

  modport source (
    output valid, found, job_index, prefer_mode,
    input  ready
  );
  modport sink (
    input  valid, found, job_index, prefer_mode,
    output ready
  );
endinterface

[rtl/speedup_aware_job_picker_core.sv]
// job table with sequential speedup scan and mode selection
// load request: accepted in idle, written to the table at that edge, no result; one per cycle
// pick request: scans n entries, n = num_entries capped at MAX_ENTRIES, then gives a result
//   (one read per entry, a drain step, a write-back on a hit); no scan for n = 0 or bad mode
// next request accepted back in idle; a pick waits in fin while an earlier result is unaccepted
// after reset a sweep marks every entry assigned, no request accepted meanwhile
module speedup_aware_job_picker_core #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sjp_in_if.sink                         in_req,
  sjp_out_if.source                      out_rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sjp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sjp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sjp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import sjp_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > NUM_W) ? CNT_W : NUM_W;
  localparam int MEM_W = SPD_W + 2;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  cfg_t cfg;

  sjp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // word: assigned, coop, speedup
  logic [MEM_W-1:0] mem [MAX_ENTRIES];
  logic [MEM_W-1:0] rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_idx_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [1:0]        rd_m3_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  data_idx_r;
  logic [1:0]        data_m3_r;

  logic [MODE_W-1:0] req_mode_r;
  logic [THR_W-1:0]  req_thr_r;
  logic [MODE_W-1:0] req_prior_r;
  logic              req_gpu_r;

  logic              hit_r;
  logic [SPD_W-1:0]  best_s_r;
  logic              best_coop_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [1:0]        best_m3_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic [ENT_W-1:0]  out_idx_r;
  logic [MODE_W-1:0] out_mode_r;

  logic [CMP_W-1:0]  ne_ext;
  logic [CNT_W-1:0]  scan_n;
  logic              accept, acc_load, acc_pick, load_ok;
  logic              do_search, gpu_side, scan_last, fin_go;
  logic [SPD_W-1:0]  rd_s;
  logic              rd_asg, rd_coop, elig, better, take;
  logic              steal;
  logic [MODE_W-1:0] prefer;

  assign ne_ext = CMP_W'(cfg.num_entries);
  assign scan_n = (ne_ext > CMP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(ne_ext);

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign acc_load     = accept && (in_req.op == OP_LOAD);
  assign acc_pick     = accept && (in_req.op == OP_PICK);
  assign load_ok      = int'(in_req.entry_index) < MAX_ENTRIES;

  assign do_search = (in_req.run_mode == MODE_CPU) || (in_req.run_mode == MODE_GPU) ||
                     (in_req.run_mode == MODE_GPU_ONLY) || (in_req.run_mode == MODE_ADAPTIVE);
  assign gpu_side  = (in_req.run_mode == MODE_GPU) || (in_req.run_mode == MODE_GPU_ONLY) ||
                     ((in_req.run_mode == MODE_ADAPTIVE) && (in_req.thread_id == GPU_THREAD));

  assign scan_last = (CNT_W'(rd_idx_r) + CNT_W'(1)) == scan_n;
  assign fin_go    = !out_valid_r || out_rsp.ready;

  // compare on returned table word
  assign rd_s    = rd_data_r[SPD_W-1:0];
  assign rd_coop = rd_data_r[SPD_W];
  assign rd_asg  = rd_data_r[SPD_W+1];
  assign elig    = !rd_asg && (req_gpu_r ? (rd_s >= cfg.gpu_run_floor)
                                         : (rd_s <= cfg.cpu_run_limit));
  assign better  = !hit_r || (req_gpu_r ? (rd_s >= best_s_r) : (rd_s < best_s_r));
  assign take    = rd_vld_r && elig && better;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = {1'b1, 1'b0, {SPD_W{1'b0}}};
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (acc_load && load_ok) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(in_req.entry_index);
      mem_wdata = {1'b0, in_req.need_coop, in_req.speedup};
    end else if ((state_r == ST_FIN) && fin_go && hit_r) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_r;
      mem_wdata = {1'b1, best_coop_r, best_s_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_idx_r == IDX_W'(MAX_ENTRIES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (acc_pick) begin
          state_nxt = (do_search && (scan_n != '0)) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN:  if (scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_SCAN);
      if (state_r == ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (acc_pick) begin
        hit_r <= 1'b0;
      end else if (take) begin
        hit_r <= 1'b1;
      end
      if ((state_r == ST_FIN) && fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_pick) begin
      req_mode_r  <= in_req.run_mode;
      req_thr_r   <= in_req.thread_id;
      req_prior_r <= in_req.prior_mode;
      req_gpu_r   <= gpu_side;
      rd_idx_r    <= '0;
      rd_m3_r     <= '0;
    end else if (state_r == ST_SCAN) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
      rd_m3_r  <= (rd_m3_r == 2'd2) ? 2'd0 : rd_m3_r + 2'd1;
    end
    data_idx_r <= rd_idx_r;
    data_m3_r  <= rd_m3_r;
    if (take) begin
      best_s_r    <= rd_s;
      best_coop_r <= rd_coop;
      best_idx_r  <= data_idx_r;
      best_m3_r   <= data_m3_r;
    end
  end

  // work-stealing mode rule
  assign steal = (best_m3_r != 2'd0);

  always_comb begin
    prefer = req_prior_r;
    if (hit_r) begin
      case (req_mode_r) inside
        MODE_ADAPTIVE: begin
          if (req_thr_r == GPU_THREAD) prefer = steal ? MODE_CPU : MODE_GPU_ONLY;
          else                         prefer = MODE_CPU;
          if (best_coop_r) prefer = MODE_ADAPTIVE;
        end
        MODE_CPU: begin
          if (best_s_r > Q_ONE) prefer = steal ? MODE_GPU_ONLY : MODE_CPU;
        end
        MODE_GPU, MODE_GPU_ONLY: begin
          if (best_s_r < Q_ONE) prefer = steal ? MODE_CPU : MODE_GPU_ONLY;
        end
        default: prefer = req_prior_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && fin_go) begin
      out_found_r <= hit_r;
      out_idx_r   <= hit_r ? ENT_W'(best_idx_r) : '0;
      out_mode_r  <= prefer;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.found       = out_found_r;
  assign out_rsp.job_index   = out_idx_r;
  assign out_rsp.prefer_mode = out_mode_r;

`ifndef ASSERT_OFF
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && out_valid_r && !out_rsp.ready |=> (state_r == ST_FIN))
    else $error("pick result left while output register still full");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (CNT_W'(data_idx_r) < scan_n))
    else $error("table read beyond scanned entries");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> (out_idx_r == '0))
    else $error("miss result carries a nonzero index");

  a_wb_hit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && (state_r == ST_FIN) |-> hit_r && mem_wdata[SPD_W+1])
    else $error("write-back without a chosen job");
`endif

endmodule

[rtl/sjp_cfg.sv]
// apb configuration registers of the job picker
module sjp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sjp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [sjp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [sjp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output sjp_pkg::cfg_t                  cfg
);
  import sjp_pkg::*;

  cfg_t       cfg_r;
  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_entries   <= RST_NUM_ENTRIES;
      cfg_r.cpu_run_limit <= RST_CPU_RUN_LIMIT;
      cfg_r.gpu_run_floor <= RST_GPU_RUN_FLOOR;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NUM_ENTRIES:   cfg_r.num_entries   <= pwdata[NUM_W-1:0];
        REG_CPU_RUN_LIMIT: cfg_r.cpu_run_limit <= pwdata[SPD_W-1:0];
        REG_GPU_RUN_FLOOR: cfg_r.gpu_run_floor <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NUM_ENTRIES:   prdata = CFG_DATA_W'(cfg_r.num_entries);
      REG_CPU_RUN_LIMIT: prdata = CFG_DATA_W'(cfg_r.cpu_run_limit);
      REG_GPU_RUN_FLOOR: prdata = CFG_DATA_W'(cfg_r.gpu_run_floor);
      default:           prdata = '0;
    endcase
  end

endmodule
